@@ hdl/scanline_flood_fill_top_defines.svh @@
// assertion macros for the scanline flood fill block
`ifndef SCANLINE_FLOOD_FILL_TOP_DEFINES_SVH
`define SCANLINE_FLOOD_FILL_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define SFF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define SFF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sff_pkg.sv @@
// shared constants for the scanline flood fill block
package sff_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_FILL = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;
   localparam int REQ_W = 2;

   // register indexes
   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_SEED_COL = 2'd2;
   localparam logic [1:0] CSR_SEED_ROW = 2'd3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // field widths and values
   localparam int PIX_W  = 8;
   localparam int AREA_W = 17;
   localparam logic [PIX_W-1:0] MASK_SET = 8'hFF;
   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 9'd256;

endpackage

@@ hdl/scanline_flood_fill_top.sv @@
// Scanline flood fill top level. A pixel load is written as it is taken; a mask read goes
// through ST_RD and ST_OUT and then waits for the result side. A fill runs a clearing sweep
// over the whole mask memory, then probes pixels and pops segments, and all probes go one
// at a time through the single read port of the image and mask memories. The block takes
// no item while a read or fill is in progress; loads are taken even while a result waits
// to be collected.
`include "scanline_flood_fill_top_defines.svh"

module scanline_flood_fill_top #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int STACK_DEPTH = 16384
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sff_pkg::REQ_W-1:0]       req_type,
   input  logic [sff_pkg::PIX_W-1:0]       req_pixel_col,
   input  logic [sff_pkg::PIX_W-1:0]       req_pixel_row,
   input  logic [sff_pkg::PIX_W-1:0]       req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sff_pkg::PIX_W-1:0]       rsp_mask_value,
   output logic [sff_pkg::AREA_W-1:0]      rsp_region_area,
   output logic                            rsp_truncated,
   output logic                            rsp_is_fill_result,
   input  logic                            csr_write_enable,
   input  logic [sff_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sff_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import sff_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int XW  = CW + 2;
   localparam int YW  = RW + 1;
   localparam int PLW = CW + 1;
   localparam int AW  = CW + RW;
   localparam int MDEPTH = 1 << AW;
   localparam int LW  = XW + YW;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SCW = $clog2(STACK_DEPTH + 1);

   // sequencer states
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_RD       = 5'd1;
   localparam logic [4:0] ST_CLR      = 5'd2;
   localparam logic [4:0] ST_INIT     = 5'd3;
   localparam logic [4:0] ST_LIM      = 5'd4;
   localparam logic [4:0] ST_SEED_RD  = 5'd5;
   localparam logic [4:0] ST_SEED_CHK = 5'd6;
   localparam logic [4:0] ST_E_MARK   = 5'd7;
   localparam logic [4:0] ST_E_L      = 5'd8;
   localparam logic [4:0] ST_E_L_RD   = 5'd9;
   localparam logic [4:0] ST_E_L_CHK  = 5'd10;
   localparam logic [4:0] ST_E_R      = 5'd11;
   localparam logic [4:0] ST_E_R_RD   = 5'd12;
   localparam logic [4:0] ST_E_R_CHK  = 5'd13;
   localparam logic [4:0] ST_E_DONE   = 5'd14;
   localparam logic [4:0] ST_P_TEST   = 5'd15;
   localparam logic [4:0] ST_P_RD     = 5'd16;
   localparam logic [4:0] ST_P_LOAD   = 5'd17;
   localparam logic [4:0] ST_S_PH     = 5'd18;
   localparam logic [4:0] ST_S_TEST   = 5'd19;
   localparam logic [4:0] ST_S_RD     = 5'd20;
   localparam logic [4:0] ST_S_CHK    = 5'd21;
   localparam logic [4:0] ST_OUT      = 5'd22;

   // scan phases of a popped segment
   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_C = 2'd2;

   typedef struct packed {
      logic [RW-1:0]  row;
      logic [CW-1:0]  left;
      logic [CW-1:0]  right;
      logic [PLW-1:0] prev_left;
      logic [CW-1:0]  prev_right;
      logic           dneg;
   } seg_type;

   // registers
   logic [4:0]            state_ff, state_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [PIX_W-1:0]      seedc_ff, seedc_in, seedr_ff, seedr_in;
   logic [XW-1:0]         fw_ff, fw_in;
   logic [YW-1:0]         fh_ff, fh_in;
   logic [LW-1:0]         limit_ff, limit_in;
   logic [RW-1:0]         prow_ff, prow_in;
   logic [XW-1:0]         pcol_ff, pcol_in;
   logic [XW-1:0]         run_l_ff, run_l_in, run_r_ff, run_r_in;
   logic [XW-1:0]         scan_i_ff, scan_i_in, scan_end_ff, scan_end_in;
   logic [1:0]            phase_ff, phase_in;
   seg_type               seg_ff, seg_in;
   logic                  push_dneg_ff, push_dneg_in;
   logic                  seed_ctx_ff, seed_ctx_in;
   logic [SCW-1:0]        count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [AREA_W-1:0]     area_ff, area_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic                  mask_init_ff, mask_init_in;
   logic                  rd_inr_ff, rd_inr_in;
   logic [PIX_W-1:0]      res_mask_ff, res_mask_in;
   logic                  res_trunc_ff, res_trunc_in;
   logic                  res_fill_ff, res_fill_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [AREA_W-1:0]     rsp_area_ff, rsp_area_in;
   logic                  rsp_trunc_ff, rsp_trunc_in;
   logic                  rsp_fill_ff, rsp_fill_in;

   // memories and their read registers
   logic                  img_mem [MDEPTH];
   logic                  mask_mem [MDEPTH];
   seg_type               stk_mem [STACK_DEPTH];
   logic                  img_rd_ff, mask_rd_ff;
   seg_type               stk_rd_ff;

   // memory ports
   logic                  img_we, img_wd;
   logic [AW-1:0]         img_waddr;
   logic                  mask_we, mask_wd;
   logic [AW-1:0]         mask_waddr, mask_raddr;
   logic                  push_en;
   seg_type               push_seg;
   logic                  stk_full;

   // helpers
   logic                  accept;
   logic                  req_inr;
   logic [AW-1:0]         req_addr, probe_addr;
   logic [LW-1:0]         lim_prod;
   logic                  use_down, nr_valid;
   logic [RW-1:0]         nr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign req_inr    = (32'(req_pixel_col) < MAX_WIDTH) && (32'(req_pixel_row) < MAX_HEIGHT);
   assign req_addr   = {RW'(req_pixel_row), CW'(req_pixel_col)};
   assign probe_addr = {prow_ff, pcol_ff[CW-1:0]};
   assign mask_raddr = (state_ff == ST_IDLE) ? req_addr : probe_addr;
   assign lim_prod   = LW'(fw_ff) * LW'(fh_ff);
   assign stk_full   = (32'(count_ff) >= STACK_DEPTH);

   // neighbor row of the current scan phase
   always_comb begin
      use_down = (phase_ff == PH_A) ? seg_ff.dneg : !seg_ff.dneg;
      if (use_down) begin
         nr_valid = ((YW'(seg_ff.row) + YW'(1)) < fh_ff);
         nr       = seg_ff.row + RW'(1);
      end else begin
         nr_valid = (seg_ff.row != '0);
         nr       = seg_ff.row - RW'(1);
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      seedc_in     = seedc_ff;
      seedr_in     = seedr_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      limit_in     = limit_ff;
      prow_in      = prow_ff;
      pcol_in      = pcol_ff;
      run_l_in     = run_l_ff;
      run_r_in     = run_r_ff;
      scan_i_in    = scan_i_ff;
      scan_end_in  = scan_end_ff;
      phase_in     = phase_ff;
      seg_in       = seg_ff;
      push_dneg_in = push_dneg_ff;
      seed_ctx_in  = seed_ctx_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      area_in      = area_ff;
      clr_in       = clr_ff;
      mask_init_in = mask_init_ff;
      rd_inr_in    = rd_inr_ff;
      res_mask_in  = res_mask_ff;
      res_trunc_in = res_trunc_ff;
      res_fill_in  = res_fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_trunc_in = rsp_trunc_ff;
      rsp_fill_in  = rsp_fill_ff;
      img_we       = 1'b0;
      img_wd       = |req_pixel_value;
      img_waddr    = req_addr;
      mask_we      = 1'b0;
      mask_wd      = 1'b1;
      mask_waddr   = probe_addr;
      push_en      = 1'b0;
      push_seg     = '0;

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:    width_in  = csr_write_data;
            CSR_HEIGHT:   height_in = csr_write_data;
            CSR_SEED_COL: seedc_in  = csr_write_data[PIX_W-1:0];
            CSR_SEED_ROW: seedr_in  = csr_write_data[PIX_W-1:0];
            default: ;
         endcase
      end

      // result register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_LOAD: img_we = req_inr;
                  REQ_FILL: begin
                     area_in  = '0;
                     count_in = '0;
                     ovf_in   = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
                  REQ_READ: begin
                     rd_inr_in = req_inr;
                     state_in  = ST_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            res_mask_in  = (rd_inr_ff && mask_init_ff && mask_rd_ff) ? MASK_SET : '0;
            res_trunc_in = 1'b0;
            res_fill_in  = 1'b0;
            state_in     = ST_OUT;
         end
         // clearing sweep over the whole mask
         ST_CLR: begin
            mask_we    = 1'b1;
            mask_wd    = 1'b0;
            mask_waddr = clr_ff;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(MDEPTH - 1)) begin
               mask_init_in = 1'b1;
               state_in     = ST_INIT;
            end
         end
         ST_INIT: begin
            fw_in    = (32'(width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_ff);
            fh_in    = (32'(height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_ff);
            state_in = ST_LIM;
         end
         ST_LIM: begin
            limit_in     = lim_prod >> 2;
            res_mask_in  = '0;
            res_trunc_in = 1'b0;
            res_fill_in  = 1'b1;
            if ((32'(seedc_ff) >= 32'(fw_ff)) || (32'(seedr_ff) >= 32'(fh_ff))) begin
               state_in = ST_OUT;
            end else begin
               prow_in  = RW'(seedr_ff);
               pcol_in  = XW'(seedc_ff);
               state_in = ST_SEED_RD;
            end
         end
         ST_SEED_RD: state_in = ST_SEED_CHK;
         ST_SEED_CHK: begin
            if (img_rd_ff) begin
               seed_ctx_in = 1'b1;
               state_in    = ST_E_MARK;
            end else begin
               state_in = ST_OUT;
            end
         end
         // run extension around the probed pixel
         ST_E_MARK: begin
            mask_we  = 1'b1;
            area_in  = area_ff + AREA_W'(1);
            run_l_in = pcol_ff;
            run_r_in = pcol_ff;
            state_in = ST_E_L;
         end
         ST_E_L: begin
            if (run_l_ff != '0) begin
               pcol_in  = run_l_ff - XW'(1);
               state_in = ST_E_L_RD;
            end else begin
               state_in = ST_E_R;
            end
         end
         ST_E_L_RD: state_in = ST_E_L_CHK;
         ST_E_L_CHK: begin
            if (img_rd_ff) begin
               mask_we  = 1'b1;
               area_in  = area_ff + AREA_W'(1);
               run_l_in = pcol_ff;
               state_in = ST_E_L;
            end else begin
               state_in = ST_E_R;
            end
         end
         ST_E_R: begin
            if ((run_r_ff + XW'(1)) < fw_ff) begin
               pcol_in  = run_r_ff + XW'(1);
               state_in = ST_E_R_RD;
            end else begin
               state_in = ST_E_DONE;
            end
         end
         ST_E_R_RD: state_in = ST_E_R_CHK;
         ST_E_R_CHK: begin
            if (img_rd_ff) begin
               mask_we  = 1'b1;
               area_in  = area_ff + AREA_W'(1);
               run_r_in = pcol_ff;
               state_in = ST_E_R;
            end else begin
               state_in = ST_E_DONE;
            end
         end
         ST_E_DONE: begin
            push_seg.row   = prow_ff;
            push_seg.left  = CW'(run_l_ff);
            push_seg.right = CW'(run_r_ff);
            if (seed_ctx_ff) begin
               push_seg.prev_left  = PLW'(run_r_ff + XW'(1));
               push_seg.prev_right = CW'(run_r_ff);
               push_seg.dneg       = (YW'(prow_ff) == (fh_ff - YW'(1)));
               seed_ctx_in         = 1'b0;
               if (fh_ff == YW'(1)) begin
                  state_in = ST_OUT;
               end else begin
                  push_en  = 1'b1;
                  state_in = ST_P_TEST;
               end
            end else begin
               push_seg.prev_left  = PLW'(seg_ff.left);
               push_seg.prev_right = seg_ff.right;
               push_seg.dneg       = push_dneg_ff;
               push_en             = 1'b1;
               scan_i_in           = run_r_ff + XW'(2);
               state_in            = ST_S_TEST;
            end
            if (push_en) begin
               if (stk_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + SCW'(1);
               end
            end
         end
         // pop loop
         ST_P_TEST: begin
            if ((count_ff != '0) && (32'(count_ff) < 32'(limit_ff))) begin
               count_in = count_ff - SCW'(1);
               state_in = ST_P_RD;
            end else begin
               res_mask_in  = '0;
               res_trunc_in = (count_ff != '0) || ovf_ff;
               res_fill_in  = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_P_RD: state_in = ST_P_LOAD;
         ST_P_LOAD: begin
            seg_in   = stk_rd_ff;
            phase_in = PH_A;
            state_in = ST_S_PH;
         end
         // set up the scan range of one phase
         ST_S_PH: begin
            if (nr_valid) begin
               prow_in      = nr;
               push_dneg_in = (phase_ff == PH_A) ? seg_ff.dneg : !seg_ff.dneg;
               case (phase_ff)
                  PH_A: begin
                     scan_i_in   = XW'(seg_ff.left);
                     scan_end_in = XW'(seg_ff.right) + XW'(1);
                  end
                  PH_B: begin
                     scan_i_in   = XW'(seg_ff.left);
                     scan_end_in = XW'(seg_ff.prev_left);
                  end
                  default: begin
                     scan_i_in   = XW'(seg_ff.prev_right) + XW'(1);
                     scan_end_in = XW'(seg_ff.right) + XW'(1);
                  end
               endcase
               state_in = ST_S_TEST;
            end else if (phase_ff == PH_C) begin
               state_in = ST_P_TEST;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_S_TEST: begin
            if (scan_i_ff < scan_end_ff) begin
               pcol_in  = scan_i_ff;
               state_in = ST_S_RD;
            end else if (phase_ff == PH_C) begin
               state_in = ST_P_TEST;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = ST_S_PH;
            end
         end
         ST_S_RD: state_in = ST_S_CHK;
         ST_S_CHK: begin
            if (img_rd_ff && !mask_rd_ff) begin
               state_in = ST_E_MARK;
            end else begin
               scan_i_in = scan_i_ff + XW'(1);
               state_in  = ST_S_TEST;
            end
         end
         // hand the result to the output register
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = res_mask_ff;
               rsp_area_in  = area_ff;
               rsp_trunc_in = res_trunc_ff;
               rsp_fill_in  = res_fill_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         seedc_ff     <= '0;
         seedr_ff     <= '0;
         count_ff     <= '0;
         area_ff      <= '0;
         ovf_ff       <= 1'b0;
         seed_ctx_ff  <= 1'b0;
         mask_init_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         seedc_ff     <= seedc_in;
         seedr_ff     <= seedr_in;
         count_ff     <= count_in;
         area_ff      <= area_in;
         ovf_ff       <= ovf_in;
         seed_ctx_ff  <= seed_ctx_in;
         mask_init_ff <= mask_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fw_ff        <= fw_in;
      fh_ff        <= fh_in;
      limit_ff     <= limit_in;
      prow_ff      <= prow_in;
      pcol_ff      <= pcol_in;
      run_l_ff     <= run_l_in;
      run_r_ff     <= run_r_in;
      scan_i_ff    <= scan_i_in;
      scan_end_ff  <= scan_end_in;
      phase_ff     <= phase_in;
      seg_ff       <= seg_in;
      push_dneg_ff <= push_dneg_in;
      clr_ff       <= clr_in;
      rd_inr_ff    <= rd_inr_in;
      res_mask_ff  <= res_mask_in;
      res_trunc_ff <= res_trunc_in;
      res_fill_ff  <= res_fill_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_area_ff  <= rsp_area_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   // image memory
   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= img_wd;
      end
      img_rd_ff <= img_mem[probe_addr];
   end

   // mask memory
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wd;
      end
      mask_rd_ff <= mask_mem[mask_raddr];
   end

   // segment stack memory
   always_ff @(posedge clock) begin
      if (push_en && !stk_full) begin
         stk_mem[count_ff[SAW-1:0]] <= push_seg;
      end
      stk_rd_ff <= stk_mem[count_ff[SAW-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mask_value     = rsp_mask_ff;
   assign rsp_region_area    = rsp_area_ff;
   assign rsp_truncated      = rsp_trunc_ff;
   assign rsp_is_fill_result = rsp_fill_ff;

   // checks
   `SFF_ASSERT_NOW(a_busy_stalls, state_ff != ST_IDLE, req_stall, "item taken while busy")
   `SFF_ASSERT_NEXT(a_fill_start, accept && (req_type == REQ_FILL),
                    (state_ff == ST_CLR) && (area_ff == '0) && (count_ff == '0),
                    "fill did not start clean")
   `SFF_ASSERT_NEXT(a_push_count, push_en && !stk_full,
                    count_ff == $past(count_ff) + SCW'(1), "stack count lost a push")

endmodule
